### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked check that also runs through reset
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/wstep_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wstep_pkg
// Types, codes and widths of the 1-D wave stencil stepper.
// ---------------------------------------------------------------------------
package wstep_pkg;

    // sizes of the stored string and its values
    localparam int MAX_POINTS  = 1024;
    localparam int VALUE_BITS  = 32;

    // field widths
    localparam int KIND_BITS   = 2;
    localparam int INDEX_BITS  = 10;
    localparam int COEF_BITS   = 31;
    localparam int COUNT_BITS  = 11;
    localparam int TDATA_BITS  = 48;
    localparam int CFG_INDEX_BITS = 1;

    // register reset values, c = 1.0 in Q1.30
    localparam logic [COEF_BITS-1:0]  COEF_ONE     = COEF_BITS'(1 << 30);
    localparam logic [COUNT_BITS-1:0] COUNT_RESET  = COUNT_BITS'(1024);

    // stencil datapath widths
    localparam int LAP_BITS    = VALUE_BITS + 2;
    localparam int LAP_LO_BITS = LAP_BITS / 2;
    localparam int LAP_HI_BITS = LAP_BITS - LAP_LO_BITS;
    localparam int PLO_BITS    = COEF_BITS + LAP_LO_BITS;
    localparam int PHI_BITS    = COEF_BITS + 1 + LAP_HI_BITS;
    localparam int PROD_BITS   = 66;
    localparam int FRAC_BITS   = 30;
    localparam int RND_BITS    = PROD_BITS - FRAC_BITS;
    localparam int BASE_BITS   = VALUE_BITS + 2;
    localparam int SUM_BITS    = RND_BITS + 1;

    // item kinds carried on tuser
    typedef enum logic [KIND_BITS-1:0] {
        KIND_LOAD = 2'd0,
        KIND_STEP = 2'd1,
        KIND_READ = 2'd2
    } t_kind;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_COURANT = 1'b0,
        CFG_POINTS  = 1'b1
    } t_cfg_reg;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_STEP,
        ST_DRAIN
    } t_state;

    // what a swept point becomes
    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_COPY,
        SEL_STENCIL
    } t_sel;

    // status from the stencil pipe to the sequencer
    typedef struct packed {
        logic wr_en;
        logic busy;
    } t_stc_status;

endpackage

### rtl/wstep_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wstep_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module wstep_ram import wstep_pkg::*; #(
    parameter int P_DEPTH = MAX_POINTS,
    parameter int P_WIDTH = VALUE_BITS,
    localparam int AW = $clog2(P_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [P_WIDTH-1:0] i_wdata,
    input  logic               i_re,
    input  logic [AW-1:0]      i_raddr,
    output logic [P_WIDTH-1:0] o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/wstep_stencil.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wstep_stencil
// Sliding three-point window and pipelined stencil arithmetic of one sweep.
// ---------------------------------------------------------------------------
module wstep_stencil import wstep_pkg::*; #(
    parameter int P_MAX_POINTS = MAX_POINTS,
    localparam int AW = $clog2(P_MAX_POINTS),
    localparam int NW = $clog2(P_MAX_POINTS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [NW-1:0]                i_k,
    input  logic [NW-1:0]                i_n_eff,
    input  logic [COEF_BITS-1:0]         i_coef,
    input  logic signed [VALUE_BITS-1:0] i_cur,
    input  logic signed [VALUE_BITS-1:0] i_old,
    output t_stc_status                  o_status,
    output logic [AW-1:0]                o_wr_addr,
    output logic [VALUE_BITS-1:0]        o_wr_data
);

    // window: cur[k-1], cur[k-2], old[k-1]
    logic signed [VALUE_BITS-1:0] r_c1;
    logic signed [VALUE_BITS-1:0] r_c2;
    logic signed [VALUE_BITS-1:0] r_o1;

    // stage a
    logic                         r_a_v;
    logic [AW-1:0]                r_a_i;
    t_sel                         r_a_sel;
    logic signed [LAP_BITS-1:0]   r_a_lap;
    logic signed [VALUE_BITS-1:0] r_a_cur;
    logic signed [VALUE_BITS-1:0] r_a_old;

    // stage b
    logic                         r_b_v;
    logic [AW-1:0]                r_b_i;
    t_sel                         r_b_sel;
    logic [PLO_BITS-1:0]          r_b_plo;
    logic signed [PHI_BITS-1:0]   r_b_phi;
    logic signed [VALUE_BITS-1:0] r_b_cur;
    logic signed [VALUE_BITS-1:0] r_b_old;

    // stage c
    logic                         r_c_v;
    logic [AW-1:0]                r_c_i;
    t_sel                         r_c_sel;
    logic signed [RND_BITS-1:0]   r_c_rnd;
    logic signed [BASE_BITS-1:0]  r_c_base;
    logic signed [VALUE_BITS-1:0] r_c_cur;

    // stage d, write-back
    logic                         r_d_v;
    logic [AW-1:0]                r_d_i;
    logic [VALUE_BITS-1:0]        r_d_val;

    logic [NW-1:0]                w_i;
    t_sel                         w_sel;
    logic signed [VALUE_BITS-1:0] w_l;
    logic signed [VALUE_BITS-1:0] w_r;
    logic signed [LAP_BITS-1:0]   w_lap;
    logic [LAP_LO_BITS-1:0]       w_lap_lo;
    logic signed [LAP_HI_BITS-1:0] w_lap_hi;
    logic signed [COEF_BITS:0]    w_coef_s;
    logic signed [PROD_BITS-1:0]  w_prod;
    logic signed [SUM_BITS-1:0]   w_sum;
    logic [VALUE_BITS-1:0]        w_sat;
    logic [VALUE_BITS-1:0]        w_res;

    // point i = k - 1 is finished when cur[k] arrives
    always_comb begin
        w_i = i_k - NW'(1);
        if (w_i == '0 || w_i == i_n_eff - NW'(1)) begin
            w_sel = SEL_ZERO;
        end else if (w_i >= i_n_eff) begin
            w_sel = SEL_COPY;
        end else begin
            w_sel = SEL_STENCIL;
        end
        // the neighbors next to the rigid ends count as zero
        w_l   = (w_i == NW'(1)) ? '0 : r_c2;
        w_r   = (w_i + NW'(2) == i_n_eff) ? '0 : i_cur;
        w_lap = LAP_BITS'(w_l) + LAP_BITS'(w_r) - (LAP_BITS'(r_c1) <<< 1);
    end

    // split the laplacian so each product stays narrow
    assign w_lap_lo = r_a_lap[LAP_LO_BITS-1:0];
    assign w_lap_hi = r_a_lap[LAP_BITS-1:LAP_LO_BITS];
    assign w_coef_s = {1'b0, i_coef};

    // recombine and round half up, floor of (p + 2^29) / 2^30
    assign w_prod = (PROD_BITS'(r_b_phi) <<< LAP_LO_BITS) + PROD_BITS'(r_b_plo)
                    + PROD_BITS'(COEF_ONE >> 1);

    // final sum and saturation to the value range
    always_comb begin
        w_sum = SUM_BITS'(r_c_rnd) + SUM_BITS'(r_c_base);
        if (&w_sum[SUM_BITS-1:VALUE_BITS-1] || ~|w_sum[SUM_BITS-1:VALUE_BITS-1]) begin
            w_sat = w_sum[VALUE_BITS-1:0];
        end else if (w_sum[SUM_BITS-1]) begin
            w_sat = {1'b1, {(VALUE_BITS-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(VALUE_BITS-1){1'b1}}};
        end
        case (r_c_sel)
            SEL_ZERO:    w_res = '0;
            SEL_COPY:    w_res = r_c_cur;
            SEL_STENCIL: w_res = w_sat;
            default:     w_res = '0;
        endcase
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            r_a_v <= i_valid && (i_k != '0);
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    // window and pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_c1 <= i_cur;
            r_c2 <= r_c1;
            r_o1 <= i_old;
        end
        r_a_i    <= w_i[AW-1:0];
        r_a_sel  <= w_sel;
        r_a_lap  <= w_lap;
        r_a_cur  <= r_c1;
        r_a_old  <= r_o1;

        r_b_i    <= r_a_i;
        r_b_sel  <= r_a_sel;
        r_b_plo  <= PLO_BITS'(i_coef) * PLO_BITS'(w_lap_lo);
        r_b_phi  <= PHI_BITS'(w_coef_s) * PHI_BITS'(w_lap_hi);
        r_b_cur  <= r_a_cur;
        r_b_old  <= r_a_old;

        r_c_i    <= r_b_i;
        r_c_sel  <= r_b_sel;
        r_c_rnd  <= w_prod[PROD_BITS-1:FRAC_BITS];
        r_c_base <= (BASE_BITS'(r_b_cur) <<< 1) - BASE_BITS'(r_b_old);
        r_c_cur  <= r_b_cur;

        r_d_i    <= r_c_i;
        r_d_val  <= w_res;
    end

    assign o_status.wr_en = r_d_v;
    assign o_status.busy  = r_a_v | r_b_v | r_c_v | r_d_v;
    assign o_wr_addr      = r_d_i;
    assign o_wr_data      = r_d_val;

endmodule

### rtl/wave_1d_stencil_stepper.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wave_1d_stencil_stepper
// Explicit three-point wave stencil over a string kept in two level RAMs.
// ---------------------------------------------------------------------------
// Input beats on the s_axis channel carry the item kind in tuser: load a
// point into both levels, advance one time step, or read a current point.
// Only reads produce an output beat on the m_axis channel.
// A load is written on acceptance and leaves the input ready. A read gives its
// beat from the output register once that register is free. A step sweeps all
// P_MAX_POINTS entries, one per cycle through the single read port of each
// level RAM, then drains read stage s1 and stencil stages a to d; its length is
// independent of point_count. Input ready is low while a read or step works.
// A waiting output beat does not block loads or steps; a read waits until the
// output register has been taken. Reset clears the control state, sets c = 1.0
// and point_count = 1024, and selects level A as current; level RAM contents
// are undefined until loaded. Configuration writes take effect at once; the
// user must write them only while the block idles; nothing enforces it.
// ---------------------------------------------------------------------------
module wave_1d_stencil_stepper import wstep_pkg::*; #(
    parameter int P_MAX_POINTS = MAX_POINTS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input beats
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [TDATA_BITS-1:0]     i_s_axis_tdata,  // point_index, load_value
    input  logic [KIND_BITS-1:0]      i_s_axis_tuser,  // kind
    // result beats
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [TDATA_BITS-1:0]     o_m_axis_tdata,  // read_index, displacement
    // configuration writes
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [COEF_BITS-1:0]      i_cfg_data
);

    localparam int AW  = $clog2(P_MAX_POINTS);
    localparam int NW  = $clog2(P_MAX_POINTS + 1);
    localparam int PAD = TDATA_BITS - VALUE_BITS - INDEX_BITS;

    t_state                  r_state, n_state;
    logic [NW-1:0]           r_k;
    logic                    r_s1_v;
    logic [NW-1:0]           r_s1_k;
    logic                    r_cur_b;
    logic [COEF_BITS-1:0]    r_coef;
    logic [COUNT_BITS-1:0]   r_pcount;
    logic [INDEX_BITS-1:0]   r_rd_idx;
    logic                    r_rd_oob;
    logic                    r_o_valid;
    logic [INDEX_BITS-1:0]   r_o_idx;
    logic [VALUE_BITS-1:0]   r_o_disp;

    t_kind                   w_kind;
    logic [INDEX_BITS-1:0]   w_idx;
    logic [VALUE_BITS-1:0]   w_load_raw;
    logic [VALUE_BITS-1:0]   w_load_val;
    logic                    w_in_range;
    logic [NW-1:0]           w_n_eff;
    logic                    w_ready;
    logic                    w_load_we;
    logic                    w_read_re;
    logic                    w_step_re;
    logic                    w_out_load;
    logic                    w_flip;

    logic                    w_we_a, w_we_b, w_re;
    logic [AW-1:0]           w_waddr, w_raddr;
    logic [VALUE_BITS-1:0]   w_wdata;
    logic [VALUE_BITS-1:0]   w_q_a, w_q_b;
    logic [VALUE_BITS-1:0]   w_cur_q, w_old_q;

    t_stc_status             w_st;
    logic [AW-1:0]           w_st_addr;
    logic [VALUE_BITS-1:0]   w_st_data;

    // input beat fields
    assign w_kind     = t_kind'(i_s_axis_tuser);
    assign w_idx      = i_s_axis_tdata[INDEX_BITS-1:0];
    assign w_load_raw = i_s_axis_tdata[INDEX_BITS+VALUE_BITS-1:INDEX_BITS];
    assign w_in_range = 32'(w_idx) < 32'(P_MAX_POINTS);

    // effective point count, clamped to 2..P_MAX_POINTS
    always_comb begin
        if (r_pcount < COUNT_BITS'(2)) begin
            w_n_eff = NW'(2);
        end else if (32'(r_pcount) > 32'(P_MAX_POINTS)) begin
            w_n_eff = NW'(P_MAX_POINTS);
        end else begin
            w_n_eff = NW'(r_pcount);
        end
    end

    // rigid ends always load as zero
    assign w_load_val = (w_idx == '0 || 32'(w_idx) == 32'(w_n_eff) - 32'd1)
                        ? '0 : w_load_raw;

    // sequencer next state and strobes
    always_comb begin
        n_state    = r_state;
        w_ready    = 1'b0;
        w_load_we  = 1'b0;
        w_read_re  = 1'b0;
        w_step_re  = 1'b0;
        w_out_load = 1'b0;
        w_flip     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_ready = 1'b1;
                if (i_s_axis_tvalid) begin
                    case (w_kind)
                        KIND_LOAD: w_load_we = w_in_range;
                        KIND_STEP: n_state = ST_STEP;
                        KIND_READ: begin
                            w_read_re = 1'b1;
                            n_state   = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                if (!r_o_valid || i_m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_STEP: begin
                w_step_re = (r_k < NW'(P_MAX_POINTS));
                if (r_k == NW'(P_MAX_POINTS)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_s1_v && !w_st.busy) begin
                    w_flip  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_s1_v    <= 1'b0;
            r_cur_b   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s1_v  <= (r_state == ST_STEP);
            r_cur_b <= r_cur_b ^ w_flip;
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // configuration registers, coefficient clipped to 1.0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef   <= COEF_ONE;
            r_pcount <= COUNT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_COURANT: r_coef <= (i_cfg_data > COEF_ONE) ? COEF_ONE : i_cfg_data;
                CFG_POINTS:  r_pcount <= i_cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // sweep counter and read bookkeeping
    always_ff @(posedge i_clk) begin
        if (r_state == ST_STEP) begin
            r_k <= r_k + NW'(1);
        end else begin
            r_k <= '0;
        end
        r_s1_k <= r_k;
        if (w_read_re) begin
            r_rd_idx <= w_idx;
            r_rd_oob <= !w_in_range;
        end
        if (w_out_load) begin
            r_o_idx  <= r_rd_idx;
            r_o_disp <= r_rd_oob ? '0 : w_cur_q;
        end
    end

    // level RAM ports: loads write both, a sweep writes the next level
    assign w_we_a  = w_load_we | (w_st.wr_en & r_cur_b);
    assign w_we_b  = w_load_we | (w_st.wr_en & !r_cur_b);
    assign w_waddr = w_st.wr_en ? w_st_addr : AW'(w_idx);
    assign w_wdata = w_st.wr_en ? w_st_data : w_load_val;
    assign w_re    = w_step_re | w_read_re;
    assign w_raddr = (r_state == ST_STEP) ? r_k[AW-1:0] : AW'(w_idx);

    wstep_ram #(
        .P_DEPTH (P_MAX_POINTS),
        .P_WIDTH (VALUE_BITS)
    ) u_level_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_q_a)
    );

    wstep_ram #(
        .P_DEPTH (P_MAX_POINTS),
        .P_WIDTH (VALUE_BITS)
    ) u_level_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_q_b)
    );

    assign w_cur_q = r_cur_b ? w_q_b : w_q_a;
    assign w_old_q = r_cur_b ? w_q_a : w_q_b;

    // stencil pipe
    wstep_stencil #(
        .P_MAX_POINTS (P_MAX_POINTS)
    ) u_stencil (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s1_v),
        .i_k       (r_s1_k),
        .i_n_eff   (w_n_eff),
        .i_coef    (r_coef),
        .i_cur     (w_cur_q),
        .i_old     (w_old_q),
        .o_status  (w_st),
        .o_wr_addr (w_st_addr),
        .o_wr_data (w_st_data)
    );

    assign o_s_axis_tready = w_ready;
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {{PAD{1'b0}}, r_o_disp, r_o_idx};

endmodule

### rtl/wstep_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wstep_checker
// Port-level checks of the wave stencil stepper, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wstep_checker import wstep_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_axis_tvalid,
    input logic                      o_s_axis_tready,
    input logic [TDATA_BITS-1:0]     i_s_axis_tdata,
    input logic [KIND_BITS-1:0]      i_s_axis_tuser,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [TDATA_BITS-1:0]     o_m_axis_tdata,
    input logic                      i_cfg_we,
    input logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input logic [COEF_BITS-1:0]      i_cfg_data
);

    logic w_in_beat;

    assign w_in_beat = i_s_axis_tvalid && o_s_axis_tready;

    // a result beat waiting on the receiver holds
    `ASSERT_CLK(a_out_hold, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)), "result beat changed while stalled")

    // reset leaves no result pending and the input open
    `ASSERT_RST(a_reset_state, !i_rst_n |=> (!o_m_axis_tvalid && o_s_axis_tready), "reset did not clear the handshake state")

    // a read keeps the input closed while the RAM answers
    `ASSERT_CLK(a_read_busy, (w_in_beat && i_s_axis_tuser == KIND_READ) |=> !o_s_axis_tready, "input open during a read")

    // a step sweep holds the input closed
    `ASSERT_CLK(a_step_busy, (w_in_beat && i_s_axis_tuser == KIND_STEP) |=> (!o_s_axis_tready ##1 !o_s_axis_tready), "input open during a step")

    // a new result beat only comes out of a read in progress
    `ASSERT_CLK(a_out_from_read, $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready), "result beat without a read")

endmodule

bind wave_1d_stencil_stepper wstep_checker u_wstep_checker (.*);
